// ===== rtl/rhsm_pkg.sv =====
// ----------------------------------------------------------------------------
// rhsm_pkg: shared constants, types and helpers
// hash modulus, base, request and status codes, symbol mapping
// ----------------------------------------------------------------------------
package rhsm_pkg;

    typedef logic [29:0] t_hash;

    localparam int    MAX_PATTERN_DEF = 64;

    localparam t_hash HASH_MOD  = 30'd1000000007;
    localparam int    HASH_BASE = 26;
    // 2^30 mod HASH_MOD, used to fold the bits above bit 29
    localparam t_hash FOLD_K    = 30'd73741817;
    // (byte - 'a') mod 26 equals (byte + SYM_BIAS) mod 26
    localparam int    ASCII_A   = 97;
    localparam int    SYM_BIAS  = HASH_BASE * 4 - ASCII_A;

    localparam logic [1:0] REQ_PATTERN = 2'd0;
    localparam logic [1:0] REQ_TEXT    = 2'd1;
    localparam logic [1:0] REQ_CLEAR   = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_PAT_FULL  = 2'd1;
    localparam logic [1:0] ST_TEXT_EXH  = 2'd2;
    localparam logic [1:0] ST_PAT_LATE  = 2'd3;

    // byte to symbol 0..25, quotient by reciprocal 79/2048 (exact below 263)
    function automatic logic [4:0] map_symbol(input logic [7:0] b);
        logic [8:0]  x;
        logic [15:0] p;
        logic [3:0]  q;
        logic [8:0]  r;
        x = {1'b0, b} + 9'(SYM_BIAS);
        p = {7'b0, x} * 16'd79;
        q = p[14:11];
        r = x - 9'({5'b0, q} * 9'(HASH_BASE));
        return r[4:0];
    endfunction

endpackage

// ===== rtl/rhsm_ram.sv =====
// ----------------------------------------------------------------------------
// rhsm_ram: generic single-write, single-read ram
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module rhsm_ram #(
    parameter int WIDTH = 5,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/rhsm_mulmod.sv =====
// ----------------------------------------------------------------------------
// rhsm_mulmod: shared modular multiply-add unit
// y = (a * b + c) mod HASH_MOD in steps: multiply, fold, two trims
// ----------------------------------------------------------------------------
module rhsm_mulmod (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  rhsm_pkg::t_hash    i_a,
    input  logic [4:0]         i_b,
    input  rhsm_pkg::t_hash    i_c,
    output logic               o_done,
    output rhsm_pkg::t_hash    o_y
);

    localparam logic [1:0] STEP_FOLD  = 2'd1;
    localparam logic [1:0] STEP_TRIM1 = 2'd2;
    localparam logic [1:0] STEP_TRIM2 = 2'd3;

    logic        r_busy;
    logic        r_done;
    logic [1:0]  r_step;
    logic [34:0] r_x;
    logic [31:0] r_f;
    logic [31:0] fold;
    logic [31:0] trim;

    // x < 27 * modulus, so x[34:30] * 2^30 folds to below 3 * modulus
    assign fold = 32'({27'b0, r_x[34:30]} * {2'b0, rhsm_pkg::FOLD_K}) + {2'b0, r_x[29:0]};
    assign trim = (r_f >= {2'b0, rhsm_pkg::HASH_MOD}) ? r_f - {2'b0, rhsm_pkg::HASH_MOD} : r_f;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= STEP_FOLD;
        end else begin
            // last trim finishing this cycle
            r_done <= !i_start && r_busy && (r_step == STEP_TRIM2);
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= STEP_FOLD;
            end else if (r_busy) begin
                case (r_step)
                    STEP_FOLD:  r_step <= STEP_TRIM1;
                    STEP_TRIM1: r_step <= STEP_TRIM2;
                    STEP_TRIM2: r_busy <= 1'b0;
                    default:    r_busy <= 1'b0;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x <= ({5'b0, i_a} * {30'b0, i_b}) + {5'b0, i_c};
        end else if (r_busy) begin
            case (r_step)
                STEP_FOLD:  r_f <= fold;
                STEP_TRIM1: r_f <= trim;
                STEP_TRIM2: r_f <= trim;
                default:    r_f <= r_f;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_y    = r_f[29:0];

endmodule

// ===== rtl/rolling_hash_substring_matcher.sv =====
// ----------------------------------------------------------------------------
// rolling_hash_substring_matcher: streaming rolling-hash substring search
// pattern words hash in the symbol and, from the second on, update the high power;
//   text words hash in the symbol, first dropping the oldest once the window is full
// words are taken one at a time, as all of them share the one mulmod unit
// reset: synchronous active low, returns to an empty pattern and text
// ----------------------------------------------------------------------------
module rolling_hash_substring_matcher #(
    parameter int MAX_PATTERN = rhsm_pkg::MAX_PATTERN_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] symbol
    input  logic [1:0]  s_axis_tuser,   // [1:0] req_type
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] match_position
    output logic [2:0]  m_axis_tuser    // [0] match_found, [2:1] status
);

    // pattern length counter holds 0..MAX_PATTERN, ring index 0..MAX_PATTERN-1
    localparam int CW = $clog2(MAX_PATTERN + 1);
    localparam int AW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int IW = CW + 1;

    // sequencer states
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_PH     = 4'd1;   // pattern hash push in flight
    localparam logic [3:0] S_PW     = 4'd2;   // high power update in flight
    localparam logic [3:0] S_RD     = 4'd3;   // oldest symbol read from ring
    localparam logic [3:0] S_POP    = 4'd4;   // oldest symbol times power in flight
    localparam logic [3:0] S_SUB    = 4'd5;   // trim the difference below modulus
    localparam logic [3:0] S_PSTART = 4'd6;   // launch the window push
    localparam logic [3:0] S_PUSH   = 4'd7;   // window hash push in flight
    localparam logic [3:0] S_CHK    = 4'd8;   // compare window with pattern
    localparam logic [3:0] S_OUT    = 4'd9;   // hand result to output register

    logic [3:0]      r_state;

    // search state
    rhsm_pkg::t_hash r_pattern_hash;
    rhsm_pkg::t_hash r_window_hash;
    rhsm_pkg::t_hash r_high_power;
    logic [CW-1:0]   r_pattern_count;
    logic [31:0]     r_text_count;
    logic [AW-1:0]   r_wr_ptr;        // text_count mod MAX_PATTERN

    // per-word working registers
    logic [4:0]      r_sym;
    logic [30:0]     r_d;

    // result waiting for the output register
    logic            r_res_found;
    logic [31:0]     r_res_pos;
    logic [1:0]      r_res_status;

    // output register
    logic            r_m_valid;
    logic            r_m_found;
    logic [31:0]     r_m_pos;
    logic [1:0]      r_m_status;

    // handshakes and decode
    logic            in_acc;
    logic            out_free;
    logic [4:0]      sym_in;
    logic            pat_late;
    logic            pat_full;
    logic            text_exh;
    logic            win_full;
    logic            pop_now;

    // ring read index (text_count - n) mod MAX_PATTERN
    logic [IW-1:0]   wide_wr;
    logic [IW-1:0]   wide_n;
    logic [IW-1:0]   rd_wide;
    logic [AW-1:0]   rd_idx;
    logic [4:0]      ram_rdata;
    logic            ram_we;

    // shared unit
    logic            mm_start;
    rhsm_pkg::t_hash mm_a;
    logic [4:0]      mm_b;
    rhsm_pkg::t_hash mm_c;
    logic            mm_done;
    rhsm_pkg::t_hash mm_y;

    // no word is taken while reset is held
    assign s_axis_tready = (r_state == S_IDLE) && i_rst_n;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_m_valid || m_axis_tready;
    assign sym_in        = rhsm_pkg::map_symbol(s_axis_tdata);

    assign pat_late = (r_text_count != 32'd0);
    assign pat_full = (r_pattern_count >= CW'(MAX_PATTERN));
    assign text_exh = (r_text_count == 32'hFFFF_FFFF);
    // window already holds n symbols, so the oldest one drops out first
    assign win_full = (r_text_count >= 32'(r_pattern_count));
    assign pop_now  = (r_pattern_count != '0) && win_full;

    assign wide_wr = IW'(r_wr_ptr);
    assign wide_n  = IW'(r_pattern_count);
    assign rd_wide = (wide_wr >= wide_n) ? wide_wr - wide_n
                                         : wide_wr + IW'(MAX_PATTERN) - wide_n;
    assign rd_idx  = rd_wide[AW-1:0];

    assign ram_we  = (r_state == S_PUSH) && mm_done;

    // ring of recent text symbols, read at the word's acceptance
    rhsm_ram #(
        .WIDTH (5),
        .DEPTH (MAX_PATTERN)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_wr_ptr),
        .i_wdata (r_sym),
        .i_raddr (rd_idx),
        .o_rdata (ram_rdata)
    );

    // operand select for the shared unit
    always_comb begin
        mm_start = 1'b0;
        mm_a     = r_pattern_hash;
        mm_b     = 5'(rhsm_pkg::HASH_BASE);
        mm_c     = '0;
        case (r_state)
            S_IDLE: begin
                if (in_acc && s_axis_tuser == rhsm_pkg::REQ_PATTERN && !pat_late && !pat_full) begin
                    mm_start = 1'b1;
                    mm_a     = r_pattern_hash;
                    mm_c     = rhsm_pkg::t_hash'(sym_in);
                end else if (in_acc && s_axis_tuser == rhsm_pkg::REQ_TEXT && !text_exh
                             && !pop_now) begin
                    mm_start = 1'b1;
                    mm_a     = r_window_hash;
                    mm_c     = rhsm_pkg::t_hash'(sym_in);
                end
            end
            S_PH: begin
                // power only grows from the second pattern symbol on
                if (mm_done && r_pattern_count != '0) begin
                    mm_start = 1'b1;
                    mm_a     = r_high_power;
                end
            end
            S_RD: begin
                mm_start = 1'b1;
                mm_a     = r_high_power;
                mm_b     = ram_rdata;
            end
            S_PSTART: begin
                mm_start = 1'b1;
                mm_a     = r_d[29:0];
                mm_c     = rhsm_pkg::t_hash'(r_sym);
            end
            default: begin
                mm_start = 1'b0;
            end
        endcase
    end

    rhsm_mulmod u_mulmod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mm_start),
        .i_a     (mm_a),
        .i_b     (mm_b),
        .i_c     (mm_c),
        .o_done  (mm_done),
        .o_y     (mm_y)
    );

    // sequencer and search state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_pattern_hash  <= '0;
            r_window_hash   <= '0;
            r_high_power    <= rhsm_pkg::t_hash'(1);
            r_pattern_count <= '0;
            r_text_count    <= '0;
            r_wr_ptr        <= '0;
            r_m_valid       <= 1'b0;
        end else begin
            // in S_OUT the output register is reloaded instead
            if (m_axis_tready && r_state != S_OUT) begin
                r_m_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_sym        <= sym_in;
                        r_res_found  <= 1'b0;
                        r_res_pos    <= '0;
                        case (s_axis_tuser)
                            rhsm_pkg::REQ_PATTERN: begin
                                // late pattern wins over full pattern
                                if (pat_late) begin
                                    r_res_status <= rhsm_pkg::ST_PAT_LATE;
                                    r_state      <= S_OUT;
                                end else if (pat_full) begin
                                    r_res_status <= rhsm_pkg::ST_PAT_FULL;
                                    r_state      <= S_OUT;
                                end else begin
                                    r_res_status <= rhsm_pkg::ST_OK;
                                    r_state      <= S_PH;
                                end
                            end
                            rhsm_pkg::REQ_TEXT: begin
                                if (text_exh) begin
                                    r_res_status <= rhsm_pkg::ST_TEXT_EXH;
                                    r_state      <= S_OUT;
                                end else if (pop_now) begin
                                    r_res_status <= rhsm_pkg::ST_OK;
                                    r_state      <= S_RD;
                                end else begin
                                    r_res_status <= rhsm_pkg::ST_OK;
                                    r_state      <= S_PUSH;
                                end
                            end
                            rhsm_pkg::REQ_CLEAR: begin
                                r_res_status    <= rhsm_pkg::ST_OK;
                                r_pattern_hash  <= '0;
                                r_window_hash   <= '0;
                                r_high_power    <= rhsm_pkg::t_hash'(1);
                                r_pattern_count <= '0;
                                r_text_count    <= '0;
                                r_wr_ptr        <= '0;
                                r_state         <= S_OUT;
                            end
                            default: begin
                                r_res_status <= rhsm_pkg::ST_OK;
                                r_state      <= S_OUT;
                            end
                        endcase
                    end
                end
                S_PH: begin
                    if (mm_done) begin
                        r_pattern_hash  <= mm_y;
                        r_pattern_count <= r_pattern_count + CW'(1);
                        r_state         <= (r_pattern_count != '0) ? S_PW : S_OUT;
                    end
                end
                S_PW: begin
                    if (mm_done) begin
                        r_high_power <= mm_y;
                        r_state      <= S_OUT;
                    end
                end
                S_RD: begin
                    r_state <= S_POP;
                end
                S_POP: begin
                    if (mm_done) begin
                        // window hash minus weighted oldest symbol, below twice the modulus
                        r_d     <= {1'b0, r_window_hash}
                                 + ({1'b0, rhsm_pkg::HASH_MOD} - {1'b0, mm_y});
                        r_state <= S_SUB;
                    end
                end
                S_SUB: begin
                    if (r_d >= {1'b0, rhsm_pkg::HASH_MOD}) begin
                        r_d <= r_d - {1'b0, rhsm_pkg::HASH_MOD};
                    end
                    r_state <= S_PSTART;
                end
                S_PSTART: begin
                    r_state <= S_PUSH;
                end
                S_PUSH: begin
                    if (mm_done) begin
                        r_window_hash <= mm_y;
                        r_text_count  <= r_text_count + 32'd1;
                        if (r_wr_ptr == AW'(MAX_PATTERN - 1)) begin
                            r_wr_ptr <= '0;
                        end else begin
                            r_wr_ptr <= r_wr_ptr + AW'(1);
                        end
                        r_state <= S_CHK;
                    end
                end
                S_CHK: begin
                    // no match on an empty pattern or a window not yet full
                    if (r_pattern_count != '0 && win_full
                        && r_window_hash == r_pattern_hash) begin
                        r_res_found <= 1'b1;
                        r_res_pos   <= r_text_count - 32'(r_pattern_count);
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (out_free) begin
                        r_m_valid  <= 1'b1;
                        r_m_found  <= r_res_found;
                        r_m_pos    <= r_res_pos;
                        r_m_status <= r_res_status;
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_pos;
    assign m_axis_tuser  = {r_m_status, r_m_found};

endmodule

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: self-checking bench for rolling_hash_substring_matcher
// drives pattern, text, clear and unused request words with random gaps and
// result stalls, predicts every result word and checks it field by field
// ----------------------------------------------------------------------------
module testbench;

    // request code the block does not use, must be ignored
    localparam logic [1:0] REQ_UNUSED  = 2'd3;
    localparam int         WORD_TARGET = 1150;
    localparam int         CYCLE_LIMIT = 600000;
    localparam int         RING        = rhsm_pkg::MAX_PATTERN_DEF;

    // one result word as the block should deliver it
    typedef struct packed {
        logic        found;
        logic [31:0] position;
        logic [1:0]  status;
    } t_match;

    // ------------------------------------------------------------------------
    // scoreboard: its own copy of the search state and the pending results
    // ------------------------------------------------------------------------
    class match_scoreboard;
        rhsm_pkg::t_hash pat_hash;
        rhsm_pkg::t_hash win_hash;
        rhsm_pkg::t_hash top_power;
        logic [6:0]      pat_len;
        logic [31:0]     text_len;
        logic [4:0]      recent [RING];
        t_match          expected_matches [$];
        int              failures;

        function new();
            failures = 0;
            clear_search();
        endfunction

        function void clear_search();
            pat_hash  = '0;
            win_hash  = '0;
            top_power = rhsm_pkg::t_hash'(1);
            pat_len   = '0;
            text_len  = '0;
        endfunction

        function rhsm_pkg::t_hash mod_mul(input rhsm_pkg::t_hash a,
                                          input rhsm_pkg::t_hash b);
            return rhsm_pkg::t_hash'((64'(a) * 64'(b)) % 64'(rhsm_pkg::HASH_MOD));
        endfunction

        function rhsm_pkg::t_hash push_symbol(input rhsm_pkg::t_hash h,
                                              input logic [4:0] sym);
            return rhsm_pkg::t_hash'((64'(h) * 64'(rhsm_pkg::HASH_BASE) + 64'(sym))
                                     % 64'(rhsm_pkg::HASH_MOD));
        endfunction

        function int pending();
            return expected_matches.size();
        endfunction

        // accepted input word: advance the search state, queue its result
        function void note_word(input logic [1:0] req, input logic [7:0] b);
            t_match          exp_r;
            logic [4:0]      sym;
            logic [31:0]     n;
            rhsm_pkg::t_hash dropped;
            exp_r = '0;
            sym   = 5'((int'(b) + rhsm_pkg::HASH_BASE
                        - rhsm_pkg::ASCII_A % rhsm_pkg::HASH_BASE) % rhsm_pkg::HASH_BASE);
            case (req)
                rhsm_pkg::REQ_PATTERN: begin
                    // late pattern wins over pattern full
                    if (text_len != 0) begin
                        exp_r.status = rhsm_pkg::ST_PAT_LATE;
                    end else if (pat_len >= RING) begin
                        exp_r.status = rhsm_pkg::ST_PAT_FULL;
                    end else begin
                        pat_hash = push_symbol(pat_hash, sym);
                        if (pat_len != 0)
                            top_power = mod_mul(top_power,
                                                rhsm_pkg::t_hash'(rhsm_pkg::HASH_BASE));
                        pat_len++;
                    end
                end
                rhsm_pkg::REQ_TEXT: begin
                    if (text_len == 32'hFFFF_FFFF) begin
                        exp_r.status = rhsm_pkg::ST_TEXT_EXH;
                    end else begin
                        n = 32'(pat_len);
                        // full window: take the oldest symbol out first
                        if (n != 0 && text_len >= n) begin
                            dropped  = mod_mul(rhsm_pkg::t_hash'(recent[(text_len - n) % RING]),
                                               top_power);
                            win_hash = rhsm_pkg::t_hash'((64'(win_hash)
                                                          + 64'(rhsm_pkg::HASH_MOD)
                                                          - 64'(dropped))
                                                         % 64'(rhsm_pkg::HASH_MOD));
                        end
                        win_hash = push_symbol(win_hash, sym);
                        recent[text_len % RING] = sym;
                        text_len++;
                        if (n != 0 && text_len >= n && win_hash == pat_hash) begin
                            exp_r.found    = 1'b1;
                            exp_r.position = text_len - n;
                        end
                    end
                end
                rhsm_pkg::REQ_CLEAR: clear_search();
                default: ;
            endcase
            expected_matches = {expected_matches, exp_r};
        endfunction

        // accepted result word against the oldest pending one
        function void check_result(input logic [31:0] data, input logic [2:0] user);
            t_match exp_r;
            if (expected_matches.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("unexpected result word: found %0b position %0d status %0d",
                             user[0], data, user[2:1]);
                return;
            end
            exp_r = expected_matches[0];
            expected_matches.delete(0);
            if (user[0] !== exp_r.found || data !== exp_r.position
                || user[2:1] !== exp_r.status) begin
                failures++;
                if (failures <= 10)
                    $display("result mismatch: found %0b/%0b position %0d/%0d status %0d/%0d",
                             exp_r.found, user[0], exp_r.position, data,
                             exp_r.status, user[2:1]);
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = '0;    // [7:0] symbol
    logic [1:0]  s_axis_tuser  = '0;    // [1:0] req_type
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;          // [31:0] match_position
    logic [2:0]  m_axis_tuser;          // [0] match_found, [2:1] status

    match_scoreboard scoreboard;
    int              words_sent  = 0;
    int              cycle_count = 0;
    // both sides run without gaps while this is set
    bit              quiet       = 1'b0;

    rolling_hash_substring_matcher uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // result side: random stalls, none in the quiet stretch
    always @(posedge i_clk) begin
        if (quiet)
            m_axis_tready <= 1'b1;
        else
            m_axis_tready <= ($urandom_range(0, 99) >= 25);
    end

    // result monitor, sees the values present at the edge
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            scoreboard.check_result(m_axis_tdata, m_axis_tuser);
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // some byte that maps onto the given symbol, high bits varied
    function automatic logic [7:0] byte_for(input logic [4:0] sym);
        int k;
        k = $urandom_range(0, (255 - (rhsm_pkg::HASH_BASE - 7) - int'(sym))
                              / rhsm_pkg::HASH_BASE);
        return 8'(int'(sym) + (rhsm_pkg::HASH_BASE - 7) + rhsm_pkg::HASH_BASE * k);
    endfunction

    // one input word, with random gaps ahead of it, held until taken
    task automatic send_word(input logic [1:0] req, input logic [7:0] sym);
        while (!quiet && $urandom_range(0, 99) < 25) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= req;
        s_axis_tdata  <= sym;
        do @(posedge i_clk); while (!s_axis_tready);
        scoreboard.note_word(req, sym);
        if (req != REQ_UNUSED)
            words_sent++;
        quiet = (words_sent >= 400 && words_sent < 600);
    endtask

    // hold off input until every pending result has come back
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (scoreboard.pending() != 0);
    endtask

    // clear, a pattern, then text with copies of the pattern and some noise
    task automatic run_search(input bit force_long);
        logic [4:0] pat [$];
        logic [4:0] sym;
        int         pat_tries;
        int         text_words;
        int         pick;
        int         alphabet;
        send_word(rhsm_pkg::REQ_CLEAR, 8'($urandom));
        // a tiny alphabet gives plenty of chance matches
        alphabet = ($urandom_range(0, 99) < 40) ? 2 : 25;
        pick     = $urandom_range(0, 99);
        if (force_long)
            pat_tries = RING + 2;
        else if (pick < 5)
            pat_tries = 0;
        else if (pick < 13)
            pat_tries = $urandom_range(RING - 4, RING + 6);
        else
            pat_tries = $urandom_range(1, 6);
        repeat (pat_tries) begin
            sym = 5'($urandom_range(0, alphabet));
            send_word(rhsm_pkg::REQ_PATTERN, byte_for(sym));
            if (pat.size() < RING)
                pat = {pat, sym};
        end
        text_words = $urandom_range(6, 30) + pat.size();
        while (text_words > 0) begin
            pick = $urandom_range(0, 99);
            if (pick < 30 && pat.size() != 0) begin
                foreach (pat[i])
                    send_word(rhsm_pkg::REQ_TEXT, byte_for(pat[i]));
                text_words -= pat.size();
            end else if (pick < 33) begin
                send_word(REQ_UNUSED, 8'($urandom));
            end else if (pick < 36) begin
                // pattern word in the middle of the text
                send_word(rhsm_pkg::REQ_PATTERN, 8'($urandom));
            end else begin
                if (pick < 45)
                    send_word(rhsm_pkg::REQ_TEXT, 8'($urandom));
                else
                    send_word(rhsm_pkg::REQ_TEXT, byte_for(5'($urandom_range(0, alphabet))));
                text_words--;
            end
        end
    endtask

    initial begin
        int searches;
        searches   = 0;
        scoreboard = new();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty pattern: text is hashed but never matched
        send_word(rhsm_pkg::REQ_TEXT, 8'h00);
        send_word(rhsm_pkg::REQ_TEXT, 8'hFF);
        // pattern after text is refused
        send_word(rhsm_pkg::REQ_PATTERN, 8'h61);
        send_word(REQ_UNUSED, 8'hAA);
        send_word(rhsm_pkg::REQ_CLEAR, 8'h55);
        // pattern a z and the top byte, an unused word in between
        send_word(rhsm_pkg::REQ_PATTERN, 8'h61);
        send_word(rhsm_pkg::REQ_PATTERN, 8'h7A);
        send_word(REQ_UNUSED, 8'h00);
        send_word(rhsm_pkg::REQ_PATTERN, 8'hFF);
        // same symbols, partly from other bytes, match at 0 then again at 3
        send_word(rhsm_pkg::REQ_TEXT, 8'h13);
        send_word(rhsm_pkg::REQ_TEXT, 8'h7A);
        send_word(rhsm_pkg::REQ_TEXT, 8'hFF);
        send_word(rhsm_pkg::REQ_TEXT, 8'h61);
        send_word(rhsm_pkg::REQ_TEXT, 8'h94);
        send_word(rhsm_pkg::REQ_TEXT, 8'h15);
        send_word(rhsm_pkg::REQ_PATTERN, 8'h80);
        // single symbol pattern, every occurrence matches
        send_word(rhsm_pkg::REQ_CLEAR, 8'hFF);
        send_word(rhsm_pkg::REQ_PATTERN, 8'h62);
        send_word(rhsm_pkg::REQ_TEXT, 8'h62);
        send_word(rhsm_pkg::REQ_TEXT, 8'h63);
        send_word(rhsm_pkg::REQ_TEXT, 8'h14);
        drain_results();

        while (words_sent < WORD_TARGET) begin
            if (searches % 8 == 7)
                drain_results();
            run_search(searches == 1);
            searches++;
        end

        drain_results();
        repeat (20) @(posedge i_clk);
        if (scoreboard.failures == 0 && scoreboard.pending() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
